@@ hdl/ypr_pkg.sv @@
// shared constants, types and register codes for the yuv pair to rgb565 writer
`default_nettype none

package ypr_pkg;

    // frame geometry limit
    localparam int MAX_DIM = 4096;

    // fixed field widths
    localparam int CFG_W  = 13;
    localparam int BYTE_W = 8;
    localparam int PIX_W  = 16;
    localparam int OFS_W  = 25;
    localparam int IDX_W  = 2;

    // widths that follow from the geometry limit
    localparam int DIM_W  = $clog2(MAX_DIM) + 1;
    localparam int CMP_W  = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int COL_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM / 2) : 1;
    localparam int PAIR_W = COL_W + 1;
    localparam int ROW_W  = DIM_W - 1;

    // arithmetic widths of the color conversion
    localparam int YW_W  = 19;
    localparam int SUM_W = 21;
    localparam int CLIP_W = 18;

    // bt.601 fixed-point weights
    localparam logic [10:0] W_Y = 11'd1192;
    localparam logic signed [SUM_W-1:0] W_VR = SUM_W'(1634);
    localparam logic signed [SUM_W-1:0] W_VG = SUM_W'(833);
    localparam logic signed [SUM_W-1:0] W_UG = SUM_W'(400);
    localparam logic signed [SUM_W-1:0] W_UB = SUM_W'(2066);
    localparam logic [BYTE_W-1:0] LUMA_BLACK = 8'd16;
    localparam logic signed [BYTE_W:0] CHROMA_MID = 9'sd128;

    // register reset values
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] LINE_STRIDE_RST  = CFG_W'(640);

    // limits compared at the common width
    localparam logic [CMP_W-1:0] DIM_MAX_C = CMP_W'(MAX_DIM);
    localparam logic [CMP_W-1:0] WIDTH_MIN_C = CMP_W'(2);
    localparam logic [CMP_W-1:0] HEIGHT_MIN_C = CMP_W'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_LINE_STRIDE  = 2'd2
    } ypr_reg_t;

    // effective frame geometry after saturation
    typedef struct packed {
        logic [PAIR_W-1:0] pairs;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  stride;
    } ypr_geom_t;

    // weighted chroma terms shared by both lanes
    typedef struct packed {
        logic signed [SUM_W-1:0] r_term;
        logic signed [SUM_W-1:0] g_term;
        logic signed [SUM_W-1:0] b_term;
    } ypr_chroma_t;

endpackage

`default_nettype wire

@@ hdl/ypr_chroma.sv @@
// chroma weighting stage shared by both pixel lanes
`default_nettype none

module ypr_chroma (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [ypr_pkg::BYTE_W-1:0]    chroma_blue,
    input  wire logic [ypr_pkg::BYTE_W-1:0]    chroma_red,
    output      ypr_pkg::ypr_chroma_t          terms
);

    logic signed [ypr_pkg::BYTE_W:0]  u_s;
    logic signed [ypr_pkg::BYTE_W:0]  v_s;
    logic signed [ypr_pkg::SUM_W-1:0] u_w;
    logic signed [ypr_pkg::SUM_W-1:0] v_w;
    ypr_pkg::ypr_chroma_t terms_reg;
    ypr_pkg::ypr_chroma_t terms_next;

    always_comb begin
        u_s = $signed({1'b0, chroma_blue}) - ypr_pkg::CHROMA_MID;
        v_s = $signed({1'b0, chroma_red}) - ypr_pkg::CHROMA_MID;
        u_w = ypr_pkg::SUM_W'(u_s);
        v_w = ypr_pkg::SUM_W'(v_s);
        terms_next.r_term = v_w * ypr_pkg::W_VR;
        terms_next.g_term = -(v_w * ypr_pkg::W_VG) - (u_w * ypr_pkg::W_UG);
        terms_next.b_term = u_w * ypr_pkg::W_UB;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

`default_nettype wire

@@ hdl/ypr_lane.sv @@
// one pixel lane: luma weighting, channel sums, clamp and rgb565 packing
`default_nettype none

module ypr_lane (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [ypr_pkg::BYTE_W-1:0]    luma,
    input  wire ypr_pkg::ypr_chroma_t          terms,
    output      logic [ypr_pkg::PIX_W-1:0]     pixel
);

    logic [ypr_pkg::BYTE_W-1:0]   luma_adj;
    logic [ypr_pkg::YW_W-1:0]     yw_reg;
    logic [ypr_pkg::YW_W-1:0]     yw_next;
    logic signed [ypr_pkg::SUM_W-1:0] yw_s;
    logic signed [ypr_pkg::SUM_W-1:0] r_sum;
    logic signed [ypr_pkg::SUM_W-1:0] g_sum;
    logic signed [ypr_pkg::SUM_W-1:0] b_sum;
    logic [ypr_pkg::CLIP_W-1:0]   r_clip;
    logic [ypr_pkg::CLIP_W-1:0]   g_clip;
    logic [ypr_pkg::CLIP_W-1:0]   b_clip;

    // clamp to 0 .. 2^18-1
    function automatic logic [ypr_pkg::CLIP_W-1:0] clip(
        input logic signed [ypr_pkg::SUM_W-1:0] sum
    );
        logic [ypr_pkg::CLIP_W-1:0] res;
        if (sum[ypr_pkg::SUM_W-1]) begin
            res = '0;
        end else if (|sum[ypr_pkg::SUM_W-2:ypr_pkg::CLIP_W]) begin
            res = '1;
        end else begin
            res = sum[ypr_pkg::CLIP_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        luma_adj = (luma < ypr_pkg::LUMA_BLACK) ? '0 : luma - ypr_pkg::LUMA_BLACK;
        yw_next  = ypr_pkg::YW_W'(luma_adj * ypr_pkg::W_Y);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yw_reg <= yw_next;
        end
    end

    always_comb begin
        yw_s   = $signed({{(ypr_pkg::SUM_W - ypr_pkg::YW_W){1'b0}}, yw_reg});
        r_sum  = yw_s + terms.r_term;
        g_sum  = yw_s + terms.g_term;
        b_sum  = yw_s + terms.b_term;
        r_clip = clip(r_sum);
        g_clip = clip(g_sum);
        b_clip = clip(b_sum);
        pixel  = {r_clip[17:13], g_clip[17:12], b_clip[17:13]};
    end

endmodule

`default_nettype wire

@@ hdl/ypr_addr.sv @@
// column and row counters giving the destination offset and end of frame
`default_nettype none

module ypr_addr (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire ypr_pkg::ypr_geom_t            geom,
    output      logic [ypr_pkg::OFS_W-1:0]     offset,
    output      logic                          last
);

    logic [ypr_pkg::COL_W-1:0]  col_reg;
    logic [ypr_pkg::COL_W-1:0]  col_next;
    logic [ypr_pkg::ROW_W-1:0]  row_reg;
    logic [ypr_pkg::ROW_W-1:0]  row_next;
    logic [ypr_pkg::OFS_W-1:0]  base_reg;
    logic [ypr_pkg::OFS_W-1:0]  base_next;
    logic [ypr_pkg::PAIR_W-1:0] col_inc;
    logic [ypr_pkg::DIM_W-1:0]  row_inc;
    logic                       row_end;

    always_comb begin
        col_inc = {1'b0, col_reg} + ypr_pkg::PAIR_W'(1);
        row_inc = {1'b0, row_reg} + ypr_pkg::DIM_W'(1);
        row_end = col_inc >= geom.pairs;
        last    = row_end && (row_inc >= geom.rows);
        offset  = base_reg + ypr_pkg::OFS_W'({col_reg, 2'b00});

        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (step) begin
            if (last) begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
            end else if (row_end) begin
                col_next  = '0;
                row_next  = row_inc[ypr_pkg::ROW_W-1:0];
                base_next = base_reg + ypr_pkg::OFS_W'({geom.stride, 1'b0});
            end else begin
                col_next  = col_inc[ypr_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/yuv_pair_to_rgb565_writer.sv @@
// top level: yuv 4:2:x pixel pair to two rgb565 pixels with destination offset
//
//  channel   dir  handshake             payload
//  s_        in   s_tvalid / s_tready   s_tdata: luma_first, luma_second, chroma_blue,
//                                       chroma_red
//  m_        out  m_tvalid / m_tready   m_tdata: pixel_first, pixel_second, dest_offset;
//                                       m_tlast: frame_last
//  cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// one beat in per clock, one beat out per clock when m_tready stays high
// the pipe registers the weighting products, then the sums, clamp and packing
// into the output register
// a stalled output holds the whole pipe; s_tready follows the output register
// aresetn clears the counters and valid flags and loads the default geometry
`default_nettype none

module yuv_pair_to_rgb565_writer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [7:0] luma_first, [15:8] luma_second, [23:16] chroma_blue, [31:24] chroma_red
    input  wire logic [31:0] s_tdata,

    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [15:0] pixel_first, [31:16] pixel_second, [56:32] dest_offset, [63:57] zero
    output      logic [63:0] m_tdata,
    output      logic        m_tlast,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [ypr_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [ypr_pkg::CFG_W-1:0] cfg_data
);

    // geometry registers
    logic [ypr_pkg::CFG_W-1:0] width_reg;
    logic [ypr_pkg::CFG_W-1:0] height_reg;
    logic [ypr_pkg::CFG_W-1:0] stride_reg;

    // saturated geometry
    logic [ypr_pkg::CMP_W-1:0] width_c;
    logic [ypr_pkg::CMP_W-1:0] height_c;
    logic [ypr_pkg::CMP_W-1:0] stride_c;
    logic [ypr_pkg::CMP_W-1:0] width_eff;
    logic [ypr_pkg::CMP_W-1:0] height_eff;
    logic [ypr_pkg::CMP_W-1:0] stride_sat;
    logic [ypr_pkg::CMP_W-1:0] stride_eff;
    ypr_pkg::ypr_geom_t        geom;

    // pipe control
    logic advance;
    logic accept;
    logic st1_valid_reg;
    logic st1_valid_next;
    logic m_valid_reg;
    logic m_valid_next;

    // stage one side data
    logic [ypr_pkg::OFS_W-1:0] offset_cur;
    logic                      last_cur;
    logic [ypr_pkg::OFS_W-1:0] st1_offset_reg;
    logic                      st1_last_reg;

    // lane results and output register
    ypr_pkg::ypr_chroma_t      terms;
    logic [ypr_pkg::PIX_W-1:0] pix_first;
    logic [ypr_pkg::PIX_W-1:0] pix_second;
    logic [ypr_pkg::PIX_W-1:0] out_first_reg;
    logic [ypr_pkg::PIX_W-1:0] out_second_reg;
    logic [ypr_pkg::OFS_W-1:0] out_offset_reg;
    logic                      out_last_reg;

    // configuration writes are taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ypr_pkg::FRAME_WIDTH_RST;
            height_reg <= ypr_pkg::FRAME_HEIGHT_RST;
            stride_reg <= ypr_pkg::LINE_STRIDE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ypr_pkg::REG_FRAME_WIDTH: begin
                    width_reg <= cfg_data;
                end
                ypr_pkg::REG_FRAME_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                ypr_pkg::REG_LINE_STRIDE: begin
                    stride_reg <= cfg_data;
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // saturate width, height and stride to the legal range, and the stride to at least the width
    always_comb begin
        width_c  = ypr_pkg::CMP_W'(width_reg);
        height_c = ypr_pkg::CMP_W'(height_reg);
        stride_c = ypr_pkg::CMP_W'(stride_reg);

        if (width_c > ypr_pkg::DIM_MAX_C) begin
            width_eff = ypr_pkg::DIM_MAX_C;
        end else if (width_c < ypr_pkg::WIDTH_MIN_C) begin
            width_eff = ypr_pkg::WIDTH_MIN_C;
        end else begin
            width_eff = width_c;
        end

        if (height_c > ypr_pkg::DIM_MAX_C) begin
            height_eff = ypr_pkg::DIM_MAX_C;
        end else if (height_c < ypr_pkg::HEIGHT_MIN_C) begin
            height_eff = ypr_pkg::HEIGHT_MIN_C;
        end else begin
            height_eff = height_c;
        end

        stride_sat = (stride_c > ypr_pkg::DIM_MAX_C) ? ypr_pkg::DIM_MAX_C : stride_c;
        stride_eff = (stride_sat < width_eff) ? width_eff : stride_sat;

        geom.pairs  = ypr_pkg::PAIR_W'(width_eff >> 1);
        geom.rows   = ypr_pkg::DIM_W'(height_eff);
        geom.stride = ypr_pkg::DIM_W'(stride_eff);
    end

    // the whole pipe moves when the output register is free or being drained
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    always_comb begin
        st1_valid_next = st1_valid_reg;
        m_valid_next   = m_valid_reg;
        if (advance) begin
            st1_valid_next = s_tvalid;
            m_valid_next   = st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // counters step on every accepted beat
    ypr_addr u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .geom    (geom),
        .offset  (offset_cur),
        .last    (last_cur)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_offset_reg <= offset_cur;
            st1_last_reg   <= last_cur;
        end
    end

    // shared chroma products
    ypr_chroma u_chroma (
        .aclk        (aclk),
        .en          (advance),
        .chroma_blue (s_tdata[23:16]),
        .chroma_red  (s_tdata[31:24]),
        .terms       (terms)
    );

    // left and right pixel lanes
    ypr_lane u_lane_first (
        .aclk  (aclk),
        .en    (advance),
        .luma  (s_tdata[7:0]),
        .terms (terms),
        .pixel (pix_first)
    );

    ypr_lane u_lane_second (
        .aclk  (aclk),
        .en    (advance),
        .luma  (s_tdata[15:8]),
        .terms (terms),
        .pixel (pix_second)
    );

    // merge both lanes with the offset into the output register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_first_reg  <= pix_first;
            out_second_reg <= pix_second;
            out_offset_reg <= st1_offset_reg;
            out_last_reg   <= st1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_offset_reg, out_second_reg, out_first_reg};

endmodule

`default_nettype wire
